// ===== rtl/core/ipf_pkg.sv =====
// package for the ipv4 pair acl filter: table size, codes and types
package ipf_pkg;
  localparam int TableEntries = 1024;
  localparam int IdxW = $clog2(TableEntries);
  localparam int CntW = IdxW + 1;
  localparam logic [15:0] EthTypeIpv4 = 16'h0800;
  localparam logic [5:0] HeaderBytes = 6'd34;
  localparam int KeyW = 64;
  localparam int FlagW = 2;

  localparam logic [1:0] StatusDone = 2'd0;
  localparam logic [1:0] StatusFull = 2'd1;
  localparam logic [1:0] StatusNotFound = 2'd2;

  localparam logic CfgLocalAddr = 1'b0;
  localparam logic CfgLocalSet = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ipf_state_t;
endpackage

// ===== rtl/core/ipf_ram.sv =====
// generic single port write, single port registered read ram
module ipf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== rtl/core/ipv4_pair_acl_filter_core.sv =====
// top level of the ipv4 pair acl filter: header capture, rule table scan and verdicts
//
// channel   | handshake                 | payload
// ----------+---------------------------+------------------------------------------
// input     | start & !busy             | in_req_type, in_byte_value, in_last_byte,
//           |                           | in_rule_source/destination/allow/remove
// result    | out_valid, one cycle      | out_result_kind, out_verdict_pass,
//           |                           | out_rule_status
// config    | cfg_valid & cfg_ready     | cfg_index, cfg_data
//
// non-last packet bytes only update the header capture and give no result
// a rule write or a last byte that needs a lookup scans the table, one entry a
// cycle through the ram read port, and is answered from the finish state
// verdicts decided by the header alone come out the cycle after acceptance
// after reset a clearing pass writes every flag entry, busy stays high
// meanwhile; the receiver cannot stall results
module ipv4_pair_acl_filter_core
  import ipf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [7:0]  in_byte_value,
  input  logic        in_last_byte,
  input  logic [31:0] in_rule_source,
  input  logic [31:0] in_rule_destination,
  input  logic        in_rule_allow,
  input  logic        in_rule_remove,
  output logic        out_valid,
  output logic        out_result_kind,
  output logic        out_verdict_pass,
  output logic [1:0]  out_rule_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  ipf_state_t state_r, state_nxt;

  // config registers
  logic [31:0] local_addr_r;
  logic        local_set_r;

  // capture
  logic [5:0]  pos_r;
  logic [15:0] ftype_r;
  logic [31:0] psrc_r, pdst_r;

  // scan context
  logic            is_rule_r, is_rule_nxt;
  logic [KeyW-1:0] key_r, key_nxt;
  logic            allow_r, allow_nxt;
  logic            remove_r, remove_nxt;
  logic [CntW-1:0] addr_r, addr_nxt;     // next address to read
  logic            rd_vld_r, rd_vld_nxt; // read data in flight belongs to addr_r-1
  logic [IdxW-1:0] rd_idx_r, rd_idx_nxt;
  logic            hit_r, hit_nxt;
  logic [IdxW-1:0] hit_idx_r, hit_idx_nxt;
  logic            hit_allow_r, hit_allow_nxt;
  logic            free_r, free_nxt;
  logic [IdxW-1:0] free_idx_r, free_idx_nxt;

  // outputs
  logic       ov_r, ov_nxt, okind_r, okind_nxt, opass_r, opass_nxt;
  logic [1:0] ostat_r, ostat_nxt;

  // ram ports
  logic            k_we, f_we;
  logic [IdxW-1:0] f_waddr, rd_addr;
  logic [KeyW-1:0] k_rdata;
  logic [FlagW-1:0] f_wdata, f_rdata;

  ipf_ram #(.Width(KeyW), .Depth(TableEntries)) u_keys (
    .clk(clk), .wr_en(k_we), .wr_addr(f_waddr), .wr_data(key_r),
    .rd_addr(rd_addr), .rd_data(k_rdata)
  );
  ipf_ram #(.Width(FlagW), .Depth(TableEntries)) u_flags (
    .clk(clk), .wr_en(f_we), .wr_addr(f_waddr), .wr_data(f_wdata),
    .rd_addr(rd_addr), .rd_data(f_rdata)
  );

  assign busy = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_result_kind = okind_r;
  assign out_verdict_pass = opass_r;
  assign out_rule_status = ostat_r;
  assign rd_addr = addr_r[IdxW-1:0];

  logic accept;
  assign accept = start && !busy;

  // header-only verdict decision
  logic        direct_pass;
  logic [5:0]  pos_after;
  logic [15:0] ftype_after;
  logic [31:0] psrc_after, pdst_after;

  always_comb begin
    ftype_after = ftype_r;
    psrc_after = psrc_r;
    pdst_after = pdst_r;
    pos_after = pos_r;
    if (pos_r < HeaderBytes) begin
      if (pos_r inside {6'd12, 6'd13}) begin
        ftype_after = {ftype_r[7:0], in_byte_value};
      end else if (pos_r inside {[6'd26:6'd29]}) begin
        psrc_after = {psrc_r[23:0], in_byte_value};
      end else if (pos_r inside {[6'd30:6'd33]}) begin
        pdst_after = {pdst_r[23:0], in_byte_value};
      end
      pos_after = pos_r + 6'd1;
    end
    direct_pass = (pos_after < HeaderBytes) || (ftype_after != EthTypeIpv4) ||
                  !local_set_r || (pdst_after != local_addr_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r <= '0;
      local_set_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CfgLocalAddr: local_addr_r <= cfg_data;
        CfgLocalSet:  local_set_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ftype_r <= '0;
      psrc_r <= '0;
      pdst_r <= '0;
    end else if (accept && !in_req_type) begin
      if (in_last_byte) begin
        pos_r <= '0;
        ftype_r <= '0;
        psrc_r <= '0;
        pdst_r <= '0;
      end else begin
        pos_r <= pos_after;
        ftype_r <= ftype_after;
        psrc_r <= psrc_after;
        pdst_r <= pdst_after;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    is_rule_nxt = is_rule_r;
    key_nxt = key_r;
    allow_nxt = allow_r;
    remove_nxt = remove_r;
    addr_nxt = addr_r;
    rd_vld_nxt = 1'b0;
    rd_idx_nxt = rd_idx_r;
    hit_nxt = hit_r;
    hit_idx_nxt = hit_idx_r;
    hit_allow_nxt = hit_allow_r;
    free_nxt = free_r;
    free_idx_nxt = free_idx_r;
    ov_nxt = 1'b0;
    okind_nxt = okind_r;
    opass_nxt = opass_r;
    ostat_nxt = ostat_r;
    k_we = 1'b0;
    f_we = 1'b0;
    f_waddr = addr_r[IdxW-1:0];
    f_wdata = '0;
    case (state_r)
      ST_CLEAR: begin
        f_we = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == CntW'(TableEntries - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          addr_nxt = '0;
          hit_nxt = 1'b0;
          free_nxt = 1'b0;
          if (in_req_type) begin
            is_rule_nxt = 1'b1;
            key_nxt = {in_rule_source, in_rule_destination};
            allow_nxt = in_rule_allow;
            remove_nxt = in_rule_remove;
            state_nxt = ST_SCAN;
          end else if (in_last_byte) begin
            is_rule_nxt = 1'b0;
            key_nxt = {psrc_after, pdst_after};
            if (direct_pass) begin
              ov_nxt = 1'b1;
              okind_nxt = 1'b0;
              opass_nxt = 1'b1;
              ostat_nxt = StatusDone;
            end else begin
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        // issue reads while addresses remain, check returned data
        if (!addr_r[IdxW]) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = addr_r[IdxW-1:0];
          addr_nxt = addr_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (f_rdata[0] && k_rdata == key_r && !hit_r) begin
            hit_nxt = 1'b1;
            hit_idx_nxt = rd_idx_r;
            hit_allow_nxt = f_rdata[1];
          end
          if (!f_rdata[0] && !free_r) begin
            free_nxt = 1'b1;
            free_idx_nxt = rd_idx_r;
          end
        end
        if (addr_r[IdxW] && !rd_vld_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        ov_nxt = 1'b1;
        okind_nxt = is_rule_r;
        opass_nxt = 1'b0;
        ostat_nxt = StatusDone;
        state_nxt = ST_IDLE;
        if (!is_rule_r) begin
          opass_nxt = hit_r && hit_allow_r;
        end else if (remove_r) begin
          if (hit_r) begin
            f_we = 1'b1;
            f_waddr = hit_idx_r;
            f_wdata = '0;
          end else begin
            ostat_nxt = StatusNotFound;
          end
        end else if (hit_r) begin
          f_we = 1'b1;
          f_waddr = hit_idx_r;
          f_wdata = {allow_r, 1'b1};
        end else if (free_r) begin
          f_we = 1'b1;
          k_we = 1'b1;
          f_waddr = free_idx_r;
          f_wdata = {allow_r, 1'b1};
        end else begin
          ostat_nxt = StatusFull;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      addr_r <= '0;
      rd_vld_r <= 1'b0;
      ov_r <= 1'b0;
      hit_r <= 1'b0;
      free_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r <= addr_nxt;
      rd_vld_r <= rd_vld_nxt;
      ov_r <= ov_nxt;
      hit_r <= hit_nxt;
      free_r <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_rule_r <= is_rule_nxt;
    key_r <= key_nxt;
    allow_r <= allow_nxt;
    remove_r <= remove_nxt;
    rd_idx_r <= rd_idx_nxt;
    hit_idx_r <= hit_idx_nxt;
    hit_allow_r <= hit_allow_nxt;
    free_idx_r <= free_idx_nxt;
    okind_r <= okind_nxt;
    opass_r <= opass_nxt;
    ostat_r <= ostat_nxt;
  end
endmodule
